@@ rtl/md5_pkg.sv @@
package md5_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned WordW     = 32;
  localparam int unsigned LenW      = 61;
  localparam int unsigned BlkWords  = 16;
  localparam int unsigned Rounds    = 64;
  localparam int unsigned WidxW     = $clog2(BlkWords);
  localparam int unsigned RndW      = $clog2(Rounds);
  localparam int unsigned PosW      = WidxW + 2;

  localparam logic [RndW-1:0] LastRnd = RndW'(Rounds - 1);
  // first byte position of the length field in the last block
  localparam logic [PosW-1:0] LenFieldPos = PosW'(56);
  localparam logic [PosW-1:0] LastPos     = PosW'(63);
  localparam logic [ByteW-1:0] PadByte    = 8'h80;
  localparam logic [WidxW-1:0] LenLoWord  = WidxW'(14);
  localparam logic [WidxW-1:0] LenHiWord  = WidxW'(15);

  localparam logic [3:0][WordW-1:0] InitChain = {
    32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  // round groups
  localparam logic [1:0] GrpF = 2'd0;
  localparam logic [1:0] GrpG = 2'd1;
  localparam logic [1:0] GrpH = 2'd2;
  localparam logic [1:0] GrpI = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WAIT_DATA,
    ST_PAD_A,
    ST_WAIT_A,
    ST_PAD_B,
    ST_WAIT_B,
    ST_EMIT
  } md5_state_e;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_MIX,
    CS_ROT,
    CS_ADD
  } md5_cstate_e;

  typedef struct packed {
    logic start;
    logic init;
  } md5_cmp_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } md5_cmp_stat_t;

  function automatic logic [WordW-1:0] round_k(logic [RndW-1:0] r);
    logic [WordW-1:0] k;
    case (r)
      6'd0:  k = 32'hD76AA478;  6'd1:  k = 32'hE8C7B756;
      6'd2:  k = 32'h242070DB;  6'd3:  k = 32'hC1BDCEEE;
      6'd4:  k = 32'hF57C0FAF;  6'd5:  k = 32'h4787C62A;
      6'd6:  k = 32'hA8304613;  6'd7:  k = 32'hFD469501;
      6'd8:  k = 32'h698098D8;  6'd9:  k = 32'h8B44F7AF;
      6'd10: k = 32'hFFFF5BB1;  6'd11: k = 32'h895CD7BE;
      6'd12: k = 32'h6B901122;  6'd13: k = 32'hFD987193;
      6'd14: k = 32'hA679438E;  6'd15: k = 32'h49B40821;
      6'd16: k = 32'hF61E2562;  6'd17: k = 32'hC040B340;
      6'd18: k = 32'h265E5A51;  6'd19: k = 32'hE9B6C7AA;
      6'd20: k = 32'hD62F105D;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hD8A1E681;  6'd23: k = 32'hE7D3FBC8;
      6'd24: k = 32'h21E1CDE6;  6'd25: k = 32'hC33707D6;
      6'd26: k = 32'hF4D50D87;  6'd27: k = 32'h455A14ED;
      6'd28: k = 32'hA9E3E905;  6'd29: k = 32'hFCEFA3F8;
      6'd30: k = 32'h676F02D9;  6'd31: k = 32'h8D2A4C8A;
      6'd32: k = 32'hFFFA3942;  6'd33: k = 32'h8771F681;
      6'd34: k = 32'h6D9D6122;  6'd35: k = 32'hFDE5380C;
      6'd36: k = 32'hA4BEEA44;  6'd37: k = 32'h4BDECFA9;
      6'd38: k = 32'hF6BB4B60;  6'd39: k = 32'hBEBFBC70;
      6'd40: k = 32'h289B7EC6;  6'd41: k = 32'hEAA127FA;
      6'd42: k = 32'hD4EF3085;  6'd43: k = 32'h04881D05;
      6'd44: k = 32'hD9D4D039;  6'd45: k = 32'hE6DB99E5;
      6'd46: k = 32'h1FA27CF8;  6'd47: k = 32'hC4AC5665;
      6'd48: k = 32'hF4292244;  6'd49: k = 32'h432AFF97;
      6'd50: k = 32'hAB9423A7;  6'd51: k = 32'hFC93A039;
      6'd52: k = 32'h655B59C3;  6'd53: k = 32'h8F0CCC92;
      6'd54: k = 32'hFFEFF47D;  6'd55: k = 32'h85845DD1;
      6'd56: k = 32'h6FA87E4F;  6'd57: k = 32'hFE2CE6E0;
      6'd58: k = 32'hA3014314;  6'd59: k = 32'h4E0811A1;
      6'd60: k = 32'hF7537E82;  6'd61: k = 32'hBD3AF235;
      6'd62: k = 32'h2AD7D2BB;  6'd63: k = 32'hEB86D391;
      default: k = 32'hEB86D391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] round_shift(logic [RndW-1:0] r);
    logic [4:0] s;
    case ({r[5:4], r[1:0]})
      {GrpF, 2'd0}: s = 5'd7;
      {GrpF, 2'd1}: s = 5'd12;
      {GrpF, 2'd2}: s = 5'd17;
      {GrpF, 2'd3}: s = 5'd22;
      {GrpG, 2'd0}: s = 5'd5;
      {GrpG, 2'd1}: s = 5'd9;
      {GrpG, 2'd2}: s = 5'd14;
      {GrpG, 2'd3}: s = 5'd20;
      {GrpH, 2'd0}: s = 5'd4;
      {GrpH, 2'd1}: s = 5'd11;
      {GrpH, 2'd2}: s = 5'd16;
      {GrpH, 2'd3}: s = 5'd23;
      {GrpI, 2'd0}: s = 5'd6;
      {GrpI, 2'd1}: s = 5'd10;
      {GrpI, 2'd2}: s = 5'd15;
      {GrpI, 2'd3}: s = 5'd21;
      default:      s = 5'd7;
    endcase
    return s;
  endfunction

  // message word used by a round, all arithmetic mod 16
  function automatic logic [WidxW-1:0] msg_index(logic [RndW-1:0] r);
    logic [WidxW-1:0] r4;
    logic [WidxW-1:0] idx;
    r4 = r[WidxW-1:0];
    case (r[5:4])
      GrpF:    idx = r4;
      GrpG:    idx = WidxW'(r4 * WidxW'(5) + WidxW'(1));
      GrpH:    idx = WidxW'(r4 * WidxW'(3) + WidxW'(5));
      GrpI:    idx = WidxW'(r4 * WidxW'(7));
      default: idx = r4;
    endcase
    return idx;
  endfunction

  // keep bytes before pos, pad byte at pos, zeros after
  function automatic logic [WordW-1:0] pad_word(logic [WordW-1:0] w,
                                                logic [WidxW-1:0] widx,
                                                logic [PosW-1:0] pos);
    logic [WordW-1:0] res;
    logic [PosW-1:0]  p;
    res = '0;
    for (int j = 0; j < 4; j++) begin
      p = {widx, 2'(j)};
      if (p < pos) begin
        res[8*j +: 8] = w[8*j +: 8];
      end else if (p == pos) begin
        res[8*j +: 8] = PadByte;
      end
    end
    return res;
  endfunction

endpackage

@@ rtl/md5_if.sv @@
interface md5_in_if;
  logic                      valid;
  logic                      ready;
  logic [md5_pkg::ByteW-1:0] data_byte;
  logic                      byte_present;
  logic                      end_of_message;

  modport source (output valid, data_byte, byte_present, end_of_message, input ready);
  modport sink   (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface md5_out_if;
  logic                      valid;
  logic                      ready;
  logic [md5_pkg::WordW-1:0] digest_word0;
  logic [md5_pkg::WordW-1:0] digest_word1;
  logic [md5_pkg::WordW-1:0] digest_word2;
  logic [md5_pkg::WordW-1:0] digest_word3;

  modport source (output valid, digest_word0, digest_word1, digest_word2, digest_word3,
                  input ready);
  modport sink   (input valid, digest_word0, digest_word1, digest_word2, digest_word3,
                  output ready);
endinterface

@@ rtl/md5_message_digest_unit.sv @@
// md5 over a byte stream, one request per byte (optionally marking end of message)
// a byte that does not fill a block does not stall; the 64th byte of a block holds
// ready low for the compression (a mix and a rotate step per round on the shared round
// adder, the chain add, the done flag); end of message adds one or two compressions
// before the digest reaches the output register; a digest waiting there does not stall
// input until the next one is done; async active-low reset restores the md5 initial state
module md5_message_digest_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  md5_in_if.sink     in_i,
  md5_out_if.source  out_o
);

  md5_pkg::md5_state_e              state_q, state_d;
  logic [md5_pkg::LenW-1:0]         len_q, len_d;
  logic                             fin_q, fin_d;
  logic                             two_q, two_d;
  logic                             out_valid_q, out_valid_d;
  logic [3:0][md5_pkg::WordW-1:0]   dig_q;
  logic [md5_pkg::WordW-1:0]        blk_q [md5_pkg::BlkWords];

  md5_pkg::md5_cmp_ctrl_t           cmp_ctrl;
  md5_pkg::md5_cmp_stat_t           cmp_st;
  logic [md5_pkg::WidxW-1:0]        word_idx;
  logic [3:0][md5_pkg::WordW-1:0]   chain;

  logic                             in_acc;
  logic                             byte_we;
  logic                             pad_we;
  logic                             pad_zero;
  logic                             len_we;
  logic                             emit_load;
  logic [md5_pkg::PosW-1:0]         pos;
  logic [2*md5_pkg::WordW-1:0]      bit_len;

  md5_compress u_compress (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (cmp_ctrl),
    .stat_o     (cmp_st),
    .word_idx_o (word_idx),
    .word_i     (blk_q[word_idx]),
    .chain_o    (chain)
  );

  assign in_acc  = in_i.valid && in_i.ready;
  assign pos     = len_q[md5_pkg::PosW-1:0];
  assign bit_len = {len_q, 3'b000};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= md5_pkg::ST_IDLE;
      len_q       <= '0;
      fin_q       <= 1'b0;
      two_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      fin_q       <= fin_d;
      two_q       <= two_d;
      out_valid_q <= out_valid_d;
    end
  end

  // block buffer, no reset: every byte lane is written before it is hashed
  always_ff @(posedge clk_i) begin
    if (byte_we) begin
      blk_q[pos[md5_pkg::PosW-1:2]][{pos[1:0], 3'b000} +: 8] <= in_i.data_byte;
    end
    if (pad_we) begin
      for (int w = 0; w < md5_pkg::BlkWords; w++) begin
        if (len_we && md5_pkg::WidxW'(w) == md5_pkg::LenLoWord) begin
          blk_q[w] <= bit_len[md5_pkg::WordW-1:0];
        end else if (len_we && md5_pkg::WidxW'(w) == md5_pkg::LenHiWord) begin
          blk_q[w] <= bit_len[2*md5_pkg::WordW-1:md5_pkg::WordW];
        end else begin
          blk_q[w] <= pad_zero ? '0
                               : md5_pkg::pad_word(blk_q[w], md5_pkg::WidxW'(w), pos);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_load) begin
      dig_q <= chain;
    end
  end

  always_comb begin
    state_d        = state_q;
    len_d          = len_q;
    fin_d          = fin_q;
    two_d          = two_q;
    out_valid_d    = out_valid_q && !out_o.ready;
    cmp_ctrl.start = 1'b0;
    cmp_ctrl.init  = 1'b0;
    byte_we        = 1'b0;
    pad_we         = 1'b0;
    pad_zero       = 1'b0;
    len_we         = 1'b0;
    emit_load      = 1'b0;
    case (state_q)
      md5_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_i.byte_present) begin
            byte_we = 1'b1;
            len_d   = len_q + 1'b1;
            if (pos == md5_pkg::LastPos) begin
              cmp_ctrl.start = 1'b1;
              fin_d          = in_i.end_of_message;
              state_d        = md5_pkg::ST_WAIT_DATA;
            end else if (in_i.end_of_message) begin
              state_d = md5_pkg::ST_PAD_A;
            end
          end else if (in_i.end_of_message) begin
            state_d = md5_pkg::ST_PAD_A;
          end
        end
      end
      md5_pkg::ST_WAIT_DATA: begin
        if (cmp_st.done) begin
          state_d = fin_q ? md5_pkg::ST_PAD_A : md5_pkg::ST_IDLE;
        end
      end
      md5_pkg::ST_PAD_A: begin
        // length fits behind the pad byte only if the pad lands before byte 56
        pad_we         = 1'b1;
        len_we         = (pos < md5_pkg::LenFieldPos);
        two_d          = !(pos < md5_pkg::LenFieldPos);
        cmp_ctrl.start = 1'b1;
        state_d        = md5_pkg::ST_WAIT_A;
      end
      md5_pkg::ST_WAIT_A: begin
        if (cmp_st.done) begin
          state_d = two_q ? md5_pkg::ST_PAD_B : md5_pkg::ST_EMIT;
        end
      end
      md5_pkg::ST_PAD_B: begin
        pad_we         = 1'b1;
        pad_zero       = 1'b1;
        len_we         = 1'b1;
        cmp_ctrl.start = 1'b1;
        state_d        = md5_pkg::ST_WAIT_B;
      end
      md5_pkg::ST_WAIT_B: begin
        if (cmp_st.done) begin
          state_d = md5_pkg::ST_EMIT;
        end
      end
      md5_pkg::ST_EMIT: begin
        if (!out_valid_q || out_o.ready) begin
          emit_load     = 1'b1;
          out_valid_d   = 1'b1;
          cmp_ctrl.init = 1'b1;
          len_d         = '0;
          fin_d         = 1'b0;
          state_d       = md5_pkg::ST_IDLE;
        end
      end
      default: state_d = md5_pkg::ST_IDLE;
    endcase
  end

  assign in_i.ready         = (state_q == md5_pkg::ST_IDLE);
  assign out_o.valid        = out_valid_q;
  assign out_o.digest_word0 = dig_q[0];
  assign out_o.digest_word1 = dig_q[1];
  assign out_o.digest_word2 = dig_q[2];
  assign out_o.digest_word3 = dig_q[3];

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !cmp_st.busy)
    else $error("input taken while compression runs");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_st.done |-> (state_q == md5_pkg::ST_WAIT_DATA || state_q == md5_pkg::ST_WAIT_A
                     || state_q == md5_pkg::ST_WAIT_B))
    else $error("compression done outside a wait state");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_load |=> len_q == '0 && out_valid_q)
    else $error("digest emit did not restart the message");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == md5_pkg::ST_PAD_B) |-> two_q && !cmp_st.busy)
    else $error("second pad block without overflow");

endmodule

@@ rtl/md5_round.sv @@
module md5_round (
  input  logic [md5_pkg::RndW-1:0]  rnd_i,
  input  logic [md5_pkg::WordW-1:0] a_i,
  input  logic [md5_pkg::WordW-1:0] b_i,
  input  logic [md5_pkg::WordW-1:0] c_i,
  input  logic [md5_pkg::WordW-1:0] d_i,
  input  logic [md5_pkg::WordW-1:0] m_i,
  input  logic [md5_pkg::WordW-1:0] sum_i,
  output logic [md5_pkg::WordW-1:0] mix_o,
  output logic [md5_pkg::WordW-1:0] nb_o
);

  logic [md5_pkg::WordW-1:0]   f;
  logic [2*md5_pkg::WordW-1:0] rot_wide;

  always_comb begin
    case (rnd_i[5:4])
      md5_pkg::GrpF: f = (b_i & c_i) | (~b_i & d_i);
      md5_pkg::GrpG: f = (b_i & d_i) | (c_i & ~d_i);
      md5_pkg::GrpH: f = b_i ^ c_i ^ d_i;
      md5_pkg::GrpI: f = c_i ^ (b_i | ~d_i);
      default:       f = b_i ^ c_i ^ d_i;
    endcase
  end

  // first half of a round
  assign mix_o = a_i + f + md5_pkg::round_k(rnd_i) + m_i;

  // second half: rotate the registered sum and add b
  assign rot_wide = {sum_i, sum_i} << md5_pkg::round_shift(rnd_i);
  assign nb_o     = b_i + rot_wide[2*md5_pkg::WordW-1:md5_pkg::WordW];

endmodule

@@ rtl/md5_compress.sv @@
module md5_compress (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  md5_pkg::md5_cmp_ctrl_t              ctrl_i,
  output md5_pkg::md5_cmp_stat_t              stat_o,
  output logic [md5_pkg::WidxW-1:0]           word_idx_o,
  input  logic [md5_pkg::WordW-1:0]           word_i,
  output logic [3:0][md5_pkg::WordW-1:0]      chain_o
);

  md5_pkg::md5_cstate_e             cst_q, cst_d;
  logic [md5_pkg::RndW-1:0]         rnd_q, rnd_d;
  logic                             done_q, done_d;
  logic [3:0][md5_pkg::WordW-1:0]   chain_q, chain_d;
  logic [md5_pkg::WordW-1:0]        a_q, a_d, b_q, b_d, c_q, c_d, d_q, d_d;
  logic [md5_pkg::WordW-1:0]        sum_q, sum_d;
  logic [md5_pkg::WordW-1:0]        mix, nb;

  md5_round u_round (
    .rnd_i (rnd_q),
    .a_i   (a_q),
    .b_i   (b_q),
    .c_i   (c_q),
    .d_i   (d_q),
    .m_i   (word_i),
    .sum_i (sum_q),
    .mix_o (mix),
    .nb_o  (nb)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cst_q   <= md5_pkg::CS_IDLE;
      rnd_q   <= '0;
      done_q  <= 1'b0;
      chain_q <= md5_pkg::InitChain;
    end else begin
      cst_q   <= cst_d;
      rnd_q   <= rnd_d;
      done_q  <= done_d;
      chain_q <= chain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    c_q   <= c_d;
    d_q   <= d_d;
    sum_q <= sum_d;
  end

  always_comb begin
    cst_d   = cst_q;
    rnd_d   = rnd_q;
    done_d  = 1'b0;
    chain_d = chain_q;
    a_d     = a_q;
    b_d     = b_q;
    c_d     = c_q;
    d_d     = d_q;
    sum_d   = sum_q;
    case (cst_q)
      md5_pkg::CS_IDLE: begin
        if (ctrl_i.init) begin
          chain_d = md5_pkg::InitChain;
        end
        if (ctrl_i.start) begin
          a_d   = chain_q[0];
          b_d   = chain_q[1];
          c_d   = chain_q[2];
          d_d   = chain_q[3];
          rnd_d = '0;
          cst_d = md5_pkg::CS_MIX;
        end
      end
      md5_pkg::CS_MIX: begin
        sum_d = mix;
        cst_d = md5_pkg::CS_ROT;
      end
      md5_pkg::CS_ROT: begin
        a_d = d_q;
        d_d = c_q;
        c_d = b_q;
        b_d = nb;
        if (rnd_q == md5_pkg::LastRnd) begin
          cst_d = md5_pkg::CS_ADD;
        end else begin
          rnd_d = rnd_q + 1'b1;
          cst_d = md5_pkg::CS_MIX;
        end
      end
      md5_pkg::CS_ADD: begin
        chain_d[0] = chain_q[0] + a_q;
        chain_d[1] = chain_q[1] + b_q;
        chain_d[2] = chain_q[2] + c_q;
        chain_d[3] = chain_q[3] + d_q;
        done_d     = 1'b1;
        cst_d      = md5_pkg::CS_IDLE;
      end
      default: cst_d = md5_pkg::CS_IDLE;
    endcase
  end

  assign word_idx_o  = md5_pkg::msg_index(rnd_q);
  assign chain_o     = chain_q;
  assign stat_o.busy = (cst_q != md5_pkg::CS_IDLE);
  assign stat_o.done = done_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cst_q == md5_pkg::CS_ADD) |=> done_q && cst_q == md5_pkg::CS_IDLE)
    else $error("chain add not followed by done");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cst_q == md5_pkg::CS_ADD) |-> rnd_q == md5_pkg::LastRnd)
    else $error("compression finished early");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cst_q == md5_pkg::CS_MIX) |=> cst_q == md5_pkg::CS_ROT && $stable(rnd_q))
    else $error("round halves out of step");

endmodule

@@ tb/md5_digest_checker.sv @@
module md5_digest_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  md5_in_if           req_i,
  md5_out_if          dig_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [3:0][md5_pkg::WordW-1:0]  chain_t;
  typedef logic [15:0][md5_pkg::WordW-1:0] block_t;

  localparam chain_t Md5Iv = {
    32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };
  localparam logic [md5_pkg::ByteW-1:0] PadMark = 8'h80;

  localparam logic [md5_pkg::WordW-1:0] SineK [64] = '{
    32'hD76AA478, 32'hE8C7B756, 32'h242070DB, 32'hC1BDCEEE,
    32'hF57C0FAF, 32'h4787C62A, 32'hA8304613, 32'hFD469501,
    32'h698098D8, 32'h8B44F7AF, 32'hFFFF5BB1, 32'h895CD7BE,
    32'h6B901122, 32'hFD987193, 32'hA679438E, 32'h49B40821,
    32'hF61E2562, 32'hC040B340, 32'h265E5A51, 32'hE9B6C7AA,
    32'hD62F105D, 32'h02441453, 32'hD8A1E681, 32'hE7D3FBC8,
    32'h21E1CDE6, 32'hC33707D6, 32'hF4D50D87, 32'h455A14ED,
    32'hA9E3E905, 32'hFCEFA3F8, 32'h676F02D9, 32'h8D2A4C8A,
    32'hFFFA3942, 32'h8771F681, 32'h6D9D6122, 32'hFDE5380C,
    32'hA4BEEA44, 32'h4BDECFA9, 32'hF6BB4B60, 32'hBEBFBC70,
    32'h289B7EC6, 32'hEAA127FA, 32'hD4EF3085, 32'h04881D05,
    32'hD9D4D039, 32'hE6DB99E5, 32'h1FA27CF8, 32'hC4AC5665,
    32'hF4292244, 32'h432AFF97, 32'hAB9423A7, 32'hFC93A039,
    32'h655B59C3, 32'h8F0CCC92, 32'hFFEFF47D, 32'h85845DD1,
    32'h6FA87E4F, 32'hFE2CE6E0, 32'hA3014314, 32'h4E0811A1,
    32'hF7537E82, 32'hBD3AF235, 32'h2AD7D2BB, 32'hEB86D391
  };

  localparam int unsigned RotAmt [4][4] = '{
    '{7, 12, 17, 22}, '{5, 9, 14, 20}, '{4, 11, 16, 23}, '{6, 10, 15, 21}
  };

  chain_t                   chain;
  block_t                   blk;
  logic [md5_pkg::LenW-1:0] byte_count;
  chain_t                   digest_q [$];
  int unsigned              errors;

  function automatic chain_t md5_compress(chain_t h, block_t m);
    logic [md5_pkg::WordW-1:0] a, b, c, d, f, sum, tmp;
    int unsigned               g, s;
    chain_t                    res;
    a = h[0];
    b = h[1];
    c = h[2];
    d = h[3];
    for (int r = 0; r < 64; r++) begin
      case (r / 16)
        0: begin
          f = (b & c) | (~b & d);
          g = r;
        end
        1: begin
          f = (b & d) | (c & ~d);
          g = (5 * r + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * r + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * r) % 16;
        end
      endcase
      sum = a + f + SineK[r] + m[g];
      s   = RotAmt[r / 16][r % 4];
      tmp = d;
      d   = c;
      c   = b;
      b   = b + ((sum << s) | (sum >> (32 - s)));
      a   = tmp;
    end
    res[0] = h[0] + a;
    res[1] = h[1] + b;
    res[2] = h[2] + c;
    res[3] = h[3] + d;
    return res;
  endfunction

  // byte lanes fill little-endian within each word
  task automatic put_lane(input int unsigned pos, input logic [md5_pkg::ByteW-1:0] b);
    blk[pos / 4][(pos % 4) * 8 +: 8] = b;
  endtask

  task automatic absorb_request(input logic [md5_pkg::ByteW-1:0] data, input logic present,
                                input logic eom);
    int unsigned pos;
    logic [63:0] bits;
    if (present) begin
      pos = byte_count[5:0];
      put_lane(pos, data);
      byte_count = byte_count + 1'b1;
      if (pos == 63) chain = md5_compress(chain, blk);
    end
    if (eom) begin
      bits = {byte_count, 3'b000};
      pos  = byte_count[5:0];
      put_lane(pos, PadMark);
      pos++;
      // no room left for the length field, pad out and spend one more block
      if (pos > 56) begin
        while (pos < 64) begin
          put_lane(pos, '0);
          pos++;
        end
        chain = md5_compress(chain, blk);
        pos = 0;
      end
      while (pos < 56) begin
        put_lane(pos, '0);
        pos++;
      end
      blk[14] = bits[31:0];
      blk[15] = bits[63:32];
      chain = md5_compress(chain, blk);
      digest_q = {digest_q, chain};
      chain = Md5Iv;
      byte_count = '0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    chain_t got, want;
    if (!rst_ni) begin
      chain = Md5Iv;
      blk = '0;
      byte_count = '0;
      digest_q.delete();
      errors = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (req_i.valid && req_i.ready) begin
        absorb_request(req_i.data_byte, req_i.byte_present, req_i.end_of_message);
      end
      if (dig_i.valid && dig_i.ready) begin
        got = {dig_i.digest_word3, dig_i.digest_word2, dig_i.digest_word1,
               dig_i.digest_word0};
        if (digest_q.size() == 0) begin
          errors++;
          $display("%0t: digest expected none actual %h", $time, got);
        end else begin
          want = digest_q.pop_front();
          for (int i = 0; i < 4; i++) begin
            if (got[i] !== want[i]) begin
              errors++;
              $display("%0t: digest_word%0d expected %h actual %h", $time, i, want[i],
                       got[i]);
            end
          end
        end
      end
      fail_count_o <= errors;
      pending_o <= digest_q.size();
    end
  end

endmodule

@@ tb/md5_message_digest_unit_tb.sv @@
module md5_message_digest_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ByteQuota   = 600;
  localparam int unsigned DrainCycles = 400;
  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned BoundaryLen [8] = '{55, 56, 57, 63, 64, 65, 119, 120};

  logic        clk;
  logic        rst_n;
  int unsigned tx_idle_pct = 10;
  int unsigned rx_idle_pct = 73;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycles = 0;
  int unsigned bytes_sent = 0;

  md5_in_if  in_if ();
  md5_out_if out_if ();

  md5_message_digest_unit u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  md5_digest_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .req_i        (in_if),
    .dig_i        (out_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("md5_message_digest_unit_tb failed");
      $finish;
    end
  end

  // returns at the edge where the request is taken, valid left high
  task automatic send_req(input logic [7:0] data, input logic present, input logic eom);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data_byte <= data;
    in_if.byte_present <= present;
    in_if.end_of_message <= eom;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  task automatic send_message(input int unsigned len);
    logic with_end;
    with_end = 1'($urandom_range(1));
    for (int unsigned i = 0; i < len; i++) begin
      // stray request with no byte, must leave the message alone
      if ($urandom_range(9) == 0) send_req(8'($urandom), 1'b0, 1'b0);
      send_req(8'($urandom), 1'b1, with_end && (i == len - 1));
      bytes_sent++;
    end
    if (len == 0 || !with_end) send_req(8'($urandom), 1'b0, 1'b1);
  endtask

  initial begin
    int unsigned len, pick, phase;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.data_byte = '0;
    in_if.byte_present = 1'b0;
    in_if.end_of_message = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty message, byte field ignored
    send_req(8'hFF, 1'b0, 1'b1);
    send_req(8'hFF, 1'b0, 1'b0);
    send_req(8'h00, 1'b1, 1'b0);
    send_req(8'h00, 1'b0, 1'b1);
    // byte and end in one request
    send_req(8'hFF, 1'b1, 1'b1);
    send_req(8'h61, 1'b1, 1'b0);
    send_req(8'h62, 1'b1, 1'b0);
    send_req(8'h63, 1'b1, 1'b1);
    send_req(8'h5A, 1'b0, 1'b0);
    send_req(8'hA5, 1'b0, 1'b1);

    while (bytes_sent < ByteQuota) begin
      phase = bytes_sent * 3 / ByteQuota;
      if (phase == 0) begin
        tx_idle_pct = 10;
        rx_idle_pct = 73;
      end else if (phase == 1) begin
        tx_idle_pct = 73;
        rx_idle_pct = 10;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      pick = $urandom_range(99);
      if (pick < 55) begin
        len = $urandom_range(15);
      end else if (pick < 85) begin
        len = BoundaryLen[$urandom_range(7)];
      end else begin
        len = $urandom_range(200, 16);
      end
      send_message(len);
    end

    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("md5_message_digest_unit_tb passed");
    end else begin
      $display("md5_message_digest_unit_tb failed");
    end
    $finish;
  end

endmodule

@@ md5_message_digest_unit.f @@
rtl/md5_pkg.sv
rtl/md5_if.sv
rtl/md5_round.sv
rtl/md5_compress.sv
rtl/md5_message_digest_unit.sv
tb/md5_digest_checker.sv
tb/md5_message_digest_unit_tb.sv
